FILE: rtl/core/nearest_four_tracker_core_defines.svh
// Assertion macros used by the checker of the nearest four tracker.
`ifndef NEAREST_FOUR_TRACKER_CORE_DEFINES_SVH
`define NEAREST_FOUR_TRACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest four tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define NFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest four tracker check failed");

`endif

FILE: rtl/core/nft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nft_pkg
// Types, widths and helper functions shared by the nearest four tracker.
// ----------------------------------------------------------------------------
package nft_pkg;

  localparam int unsigned KEEP      = 4;
  localparam int unsigned SHOWN     = 4;
  localparam int unsigned CNT_W     = $clog2(KEEP + 1);
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned OFS_W     = 16;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned DIST_W    = 32;

  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [MAG_W-1:0]   mag_t;
  typedef logic [CNT_W-1:0]   fill_t;
  typedef logic [COUNT_W-1:0] count_t;

  // One ranked candidate handed from the distance stages to the list stage.
  typedef struct packed {
    logic  restart;
    dist_t sq_dist;
    id_t   id;
  } ranked_t;

  // Magnitude of a two's complement offset; the most negative value maps to
  // its true magnitude, which still fits in the unsigned width.
  function automatic mag_t abs_ofs(input logic [OFS_W-1:0] v);
    logic [OFS_W-1:0] neg;
    neg = ~v + 1'b1;
    return v[OFS_W-1] ? mag_t'(neg) : mag_t'(v);
  endfunction

  // Reported count saturates at the largest value of the output field.
  function automatic count_t sat_count(input fill_t c);
    return (int'(c) > COUNT_MAX) ? {COUNT_W{1'b1}} : count_t'(c);
  endfunction

endpackage

FILE: rtl/core/nft_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nft_if
// Valid/ready channels carrying candidates in and ranked lists out.
// ----------------------------------------------------------------------------
interface nft_in_if;
  logic                              valid;
  logic                              ready;
  logic                              restart;
  logic signed [nft_pkg::OFS_W-1:0]  dx;
  logic signed [nft_pkg::OFS_W-1:0]  dy;
  logic        [nft_pkg::ID_W-1:0]   cand_index;

  modport source (output valid, restart, dx, dy, cand_index, input ready);
  modport sink   (input valid, restart, dx, dy, cand_index, output ready);
endinterface

interface nft_out_if;
  logic                          valid;
  logic                          ready;
  logic [nft_pkg::COUNT_W-1:0]   count;
  logic                          taken;
  logic [nft_pkg::ID_W-1:0]      near_id0;
  logic [nft_pkg::ID_W-1:0]      near_id1;
  logic [nft_pkg::ID_W-1:0]      near_id2;
  logic [nft_pkg::ID_W-1:0]      near_id3;
  logic [nft_pkg::DIST_W-1:0]    near_d0;
  logic [nft_pkg::DIST_W-1:0]    near_d1;
  logic [nft_pkg::DIST_W-1:0]    near_d2;
  logic [nft_pkg::DIST_W-1:0]    near_d3;

  modport source (output valid, count, taken, near_id0, near_id1, near_id2, near_id3,
                  near_d0, near_d1, near_d2, near_d3, input ready);
  modport sink   (input valid, count, taken, near_id0, near_id1, near_id2, near_id3,
                  near_d0, near_d1, near_d2, near_d3, output ready);
endinterface

FILE: rtl/core/nearest_four_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_four_tracker_core
// Tracks the four candidates closest to a target point.
// ----------------------------------------------------------------------------
// Usage:
// The item channel offers one candidate per transaction: its signed offset
// (dx, dy) from the target and an identifier. Setting restart empties the
// list before that candidate goes in. Every accepted transaction yields one
// transaction on the result channel with the fill count, a flag telling
// whether the candidate entered the list, and the four list entries ordered
// by ascending squared distance; empty lanes read as zero.
// From acceptance, a candidate moves through the input register, the squared
// distance register and the result register to a valid result. The list
// update is a four-way compare and shift done combinationally, so the
// block sustains one transaction per clock while the receiver does not stall.
// Reset empties the list and drops any transactions in flight. When the
// receiver stalls, the result register holds and the two earlier stages keep
// filling, so up to three transactions sit inside before ready falls.
// ----------------------------------------------------------------------------
module nearest_four_tracker_core (
  input  logic      clk,
  input  logic      rst,
  nft_in_if.sink    item,
  nft_out_if.source result
);

  // Handshake and payload between the distance stages and the list stage.
  logic             rk_valid;
  logic             rk_ready;
  nft_pkg::ranked_t rk_item;

  // Magnitudes, squares and their sum over two registered stages.
  nft_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .dn_valid (rk_valid),
    .dn_ready (rk_ready),
    .dn_item  (rk_item)
  );

  // Sorted insertion into the list and the result register.
  nft_list u_list (
    .clk      (clk),
    .rst      (rst),
    .up_valid (rk_valid),
    .up_ready (rk_ready),
    .up_item  (rk_item),
    .result   (result)
  );

endmodule

FILE: rtl/core/nft_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nft_dist
// Input register and squared distance stage of the nearest four tracker.
// ----------------------------------------------------------------------------
module nft_dist (
  input  logic             clk,
  input  logic             rst,
  nft_in_if.sink           item,
  output logic             dn_valid,
  input  logic             dn_ready,
  output nft_pkg::ranked_t dn_item
);

  logic                             v1;
  logic                             v2;
  logic                             s1_load;
  logic                             s2_load;
  logic                             restart1;
  nft_pkg::mag_t                    ax;
  nft_pkg::mag_t                    ay;
  nft_pkg::id_t                     id1;
  logic [2*nft_pkg::MAG_W-1:0]      sq_x;
  logic [2*nft_pkg::MAG_W-1:0]      sq_y;
  logic [2*nft_pkg::MAG_W:0]        sum;
  nft_pkg::ranked_t                 ranked;

  // Each stage loads when it is empty or its contents move on.
  always_comb begin
    s2_load    = !v2 || dn_ready;
    s1_load    = !v1 || s2_load;
    item.ready = s1_load;
  end

  always_comb begin
    sq_x = ax * ax;
    sq_y = ay * ay;
    sum  = {1'b0, sq_x} + {1'b0, sq_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (s1_load) v1 <= item.valid;
      if (s2_load) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && item.valid) begin
      restart1 <= item.restart;
      ax       <= nft_pkg::abs_ofs(item.dx);
      ay       <= nft_pkg::abs_ofs(item.dy);
      id1      <= item.cand_index;
    end
    if (s2_load && v1) begin
      // The sum never exceeds 2^31, so the top bit is always zero.
      ranked.restart <= restart1;
      ranked.sq_dist <= nft_pkg::dist_t'(sum);
      ranked.id      <= id1;
    end
  end

  assign dn_valid = v2;
  assign dn_item  = ranked;

endmodule

FILE: rtl/core/nft_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nft_list
// Sorted candidate list with combinational insertion and the result register.
// ----------------------------------------------------------------------------
module nft_list (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  nft_pkg::ranked_t up_item,
  nft_out_if.source        result
);

  nft_pkg::dist_t  dist_q    [nft_pkg::KEEP];
  nft_pkg::id_t    id_q      [nft_pkg::KEEP];
  nft_pkg::dist_t  dist_next [nft_pkg::KEEP];
  nft_pkg::id_t    id_next   [nft_pkg::KEEP];
  nft_pkg::fill_t  fill;
  nft_pkg::fill_t  fill_next;
  nft_pkg::fill_t  eff;
  logic [nft_pkg::KEEP-1:0] ahead;
  logic            taken;
  logic            adv;
  logic            fire;
  logic            ov;
  nft_pkg::count_t count_r;
  logic            taken_r;
  nft_pkg::dist_t  d_lane  [nft_pkg::SHOWN];
  nft_pkg::id_t    id_lane [nft_pkg::SHOWN];
  nft_pkg::dist_t  d_r     [nft_pkg::SHOWN];
  nft_pkg::id_t    id_r    [nft_pkg::SHOWN];

  always_comb begin
    adv      = !ov || result.ready;
    up_ready = adv;
    fire     = up_valid && adv;
  end

  // Entries that stay ahead of the candidate form a prefix of the sorted list.
  always_comb begin
    eff = up_item.restart ? '0 : fill;
    for (int k = 0; k < nft_pkg::KEEP; k++) begin
      ahead[k] = (nft_pkg::fill_t'(k) < eff) && !(up_item.sq_dist < dist_q[k]);
    end
    taken     = !ahead[nft_pkg::KEEP-1];
    fill_next = (eff < nft_pkg::fill_t'(nft_pkg::KEEP)) ? eff + 1'b1 : eff;
  end

  always_comb begin
    dist_next[0] = ahead[0] ? dist_q[0] : up_item.sq_dist;
    id_next[0]   = ahead[0] ? id_q[0]   : up_item.id;
    for (int k = 1; k < nft_pkg::KEEP; k++) begin
      if (ahead[k]) begin
        dist_next[k] = dist_q[k];
        id_next[k]   = id_q[k];
      end else if (ahead[k-1]) begin
        dist_next[k] = up_item.sq_dist;
        id_next[k]   = up_item.id;
      end else begin
        dist_next[k] = dist_q[k-1];
        id_next[k]   = id_q[k-1];
      end
    end
  end

  // Lanes past the fill level, or past the list depth, show zero.
  for (genvar s = 0; s < nft_pkg::SHOWN; s++) begin : g_lane
    if (s < nft_pkg::KEEP) begin : g_live
      always_comb begin
        if (nft_pkg::fill_t'(s) < fill_next) begin
          d_lane[s]  = dist_next[s];
          id_lane[s] = id_next[s];
        end else begin
          d_lane[s]  = '0;
          id_lane[s] = '0;
        end
      end
    end else begin : g_none
      assign d_lane[s]  = '0;
      assign id_lane[s] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ov   <= 1'b0;
    end else begin
      if (fire) fill <= fill_next;
      if (adv)  ov   <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && taken) begin
      dist_q <= dist_next;
      id_q   <= id_next;
    end
    if (fire) begin
      count_r <= nft_pkg::sat_count(fill_next);
      taken_r <= taken;
      d_r     <= d_lane;
      id_r    <= id_lane;
    end
  end

  assign result.valid    = ov;
  assign result.count    = count_r;
  assign result.taken    = taken_r;
  assign result.near_id0 = id_r[0];
  assign result.near_id1 = id_r[1];
  assign result.near_id2 = id_r[2];
  assign result.near_id3 = id_r[3];
  assign result.near_d0  = d_r[0];
  assign result.near_d1  = d_r[1];
  assign result.near_d2  = d_r[2];
  assign result.near_d3  = d_r[3];

endmodule

FILE: rtl/core/nft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nft_checker
// Port-level checks on the result channel of the nearest four tracker.
// ----------------------------------------------------------------------------
`include "nearest_four_tracker_core_defines.svh"

module nft_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [nft_pkg::COUNT_W-1:0] count,
  input logic [nft_pkg::ID_W-1:0]    near_id3,
  input logic [nft_pkg::DIST_W-1:0]  near_d0,
  input logic [nft_pkg::DIST_W-1:0]  near_d1,
  input logic [nft_pkg::DIST_W-1:0]  near_d2,
  input logic [nft_pkg::DIST_W-1:0]  near_d3
);

  // A stalled result stays valid and keeps its first distance and its count.
  `NFT_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(near_d0) && $stable(count))

  // The list never holds more than its depth.
  `NFT_ASSERT_NOW(a_count, clk, rst, res_valid, int'(count) <= nft_pkg::KEEP)

  // Shown entries are sorted by ascending distance.
  `NFT_ASSERT_NOW(a_sorted, clk, rst, res_valid, (count < 3'd2 || near_d0 <= near_d1) && (count < 3'd3 || near_d1 <= near_d2) && (count < 3'd4 || near_d2 <= near_d3))

  // The last lane reads as zero while the list is not full.
  `NFT_ASSERT_NOW(a_empty, clk, rst, res_valid && count < 3'd4, near_d3 == '0 && near_id3 == '0)

endmodule

bind nearest_four_tracker_core nft_checker u_nft_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .count     (result.count),
  .near_id3  (result.near_id3),
  .near_d0   (result.near_d0),
  .near_d1   (result.near_d1),
  .near_d2   (result.near_d2),
  .near_d3   (result.near_d3)
);

FILE: tb/sv/nearest_four_tracker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_four_tracker_core_tb
// Self-checking bench for the nearest four tracker. Candidates go in on the
// item channel. A behavioral ranking of the same list predicts every result
// transaction, and each result is compared field by field in arrival order.
// Both channels stall at random. One phase holds the result channel off long
// enough to back up the block, and another drains the block before going on.
// ----------------------------------------------------------------------------
module nearest_four_tracker_core_tb;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 320;

  // One expected result transaction: fill count, taken flag and the four
  // shown lanes of the list, closest first.
  typedef struct packed {
    nft_pkg::count_t                                  count;
    logic                                             taken;
    logic [nft_pkg::SHOWN-1:0][nft_pkg::ID_W-1:0]     ids;
    logic [nft_pkg::SHOWN-1:0][nft_pkg::DIST_W-1:0]   dists;
  } near_list_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nft_in_if  item_if ();
  nft_out_if res_if ();

  nearest_four_tracker_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (res_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted list contents. Entries at or beyond list_fill are never shown.
  nft_pkg::dist_t list_dist [nft_pkg::KEEP];
  nft_pkg::id_t   list_id   [nft_pkg::KEEP];
  int unsigned    list_fill = 0;

  near_list_t  pending_lists [$];
  int unsigned mismatches = 0;
  int unsigned hold_request = 0;
  bit          calm = 1'b0;

  // Ranks one candidate into the predicted list and returns the result
  // transaction the block should produce for it.
  function automatic near_list_t rank_candidate(input logic rs, input logic [15:0] x,
                                                input logic [15:0] y, input logic [15:0] id);
    logic [16:0]    ax;
    logic [16:0]    ay;
    nft_pkg::dist_t d;
    int unsigned    pos;
    int unsigned    j;
    near_list_t     r;
    // The magnitude of -32768 is 32768, which still fits in sixteen bits.
    ax = x[15] ? 17'h10000 - {1'b0, x} : {1'b0, x};
    ay = y[15] ? 17'h10000 - {1'b0, y} : {1'b0, y};
    d = nft_pkg::dist_t'(ax) * nft_pkg::dist_t'(ax) +
        nft_pkg::dist_t'(ay) * nft_pkg::dist_t'(ay);
    if (rs) begin
      list_fill = 0;
    end
    // Ties go after the existing entry, so only a strictly larger entry stops
    // the search.
    pos = 0;
    while (pos < list_fill && !(d < list_dist[pos])) begin
      pos++;
    end
    r = '0;
    if (pos < list_fill || list_fill < nft_pkg::KEEP) begin
      j = (list_fill < nft_pkg::KEEP) ? list_fill : nft_pkg::KEEP - 1;
      while (j > pos) begin
        list_dist[j] = list_dist[j-1];
        list_id[j]   = list_id[j-1];
        j--;
      end
      list_dist[pos] = d;
      list_id[pos]   = id;
      if (list_fill < nft_pkg::KEEP) begin
        list_fill++;
      end
      r.taken = 1'b1;
    end
    r.count = (list_fill > nft_pkg::COUNT_MAX) ? nft_pkg::count_t'(nft_pkg::COUNT_MAX)
                                                : nft_pkg::count_t'(list_fill);
    for (int k = 0; k < nft_pkg::SHOWN; k++) begin
      if (k < list_fill && k < nft_pkg::KEEP) begin
        r.ids[k]   = list_id[k];
        r.dists[k] = list_dist[k];
      end
    end
    return r;
  endfunction

  // Offers one candidate, waits for the handshake and records the expected
  // result. Valid is left high so back-to-back transactions need no gap.
  task automatic send_cand(input logic rs, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] id);
    if (!calm && $urandom_range(99) < 8) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_if.valid      <= 1'b1;
    item_if.restart    <= rs;
    item_if.dx         <= x;
    item_if.dy         <= y;
    item_if.cand_index <= id;
    do @(posedge clk); while (!item_if.ready);
    pending_lists.push_back(rank_candidate(rs, x, y, id));
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (pending_lists.size() != 0) @(posedge clk);
  endtask

  // Offsets are drawn mostly small so that ties and near ties are common, with
  // some full range values and the extremes mixed in.
  function automatic logic [15:0] pick_offset();
    int unsigned mode;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      return 16'($signed($urandom_range(6)) - 3);
    end else if (mode <= 6) begin
      return 16'($signed($urandom_range(510)) - 255);
    end else if (mode <= 8) begin
      return 16'($urandom);
    end
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'h0000;
    endcase
  endfunction

  // Ties, the extreme offsets, the full list dropping its farthest entry, and
  // candidates refused by a full list.
  task automatic test_directed();
    send_cand(1'b0, 16'sd3, 16'sd4, 16'h0001);
    send_cand(1'b0, -16'sd3, 16'sd4, 16'h0002);
    send_cand(1'b0, 16'sd0, 16'sd0, 16'h0000);
    send_cand(1'b0, 16'h8000, 16'h8000, 16'hFFFF);
    send_cand(1'b0, 16'h7FFF, 16'h7FFF, 16'hAAAA);
    send_cand(1'b0, 16'h7FFF, 16'h7FFF, 16'h5555);
    send_cand(1'b0, 16'h8000, 16'h8000, 16'h1234);
    send_cand(1'b0, 16'sd5, 16'sd0, 16'h8001);
    send_cand(1'b0, 16'sd0, -16'sd1, 16'h7FFE);
    send_cand(1'b1, 16'h8000, 16'sd0, 16'hFFFF);
    send_cand(1'b1, 16'sd0, 16'sd0, 16'h0000);
    send_cand(1'b0, 16'sd0, 16'sd0, 16'h0001);
    send_cand(1'b0, 16'sd0, 16'sd0, 16'h0002);
    send_cand(1'b0, 16'sd0, 16'sd0, 16'h0003);
    send_cand(1'b0, 16'sd0, 16'sd0, 16'h0004);
    send_cand(1'b0, 16'sd1, -16'sd1, 16'hC3C3);
    send_cand(1'b1, 16'h7FFF, 16'h8000, 16'h3C3C);
  endtask

  // Runs of candidates that each start with a restart, so the list fills and
  // overflows, with single noisy transactions in between.
  task automatic test_random();
    int unsigned sent;
    int unsigned run_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 150 && sent < 230);
      if ($urandom_range(9) == 0) begin
        send_cand(1'($urandom), pick_offset(), pick_offset(), 16'($urandom));
        sent++;
      end else begin
        run_len = $urandom_range(1, 14);
        for (int n = 0; n < run_len; n++) begin
          send_cand((n == 0) || ($urandom_range(29) == 0), pick_offset(), pick_offset(),
                    16'($urandom));
        end
        sent += run_len;
      end
    end
    calm = 1'b0;
  endtask

  // The receiver holds off for a long stretch while candidates keep coming,
  // which fills the pipeline and must stall the item channel.
  task automatic test_backpressure();
    calm = 1'b1;
    hold_request = 200;
    for (int n = 0; n < 40; n++) begin
      send_cand(n % 9 == 0, pick_offset(), pick_offset(), 16'($urandom));
    end
    calm = 1'b0;
  endtask

  // The sender stops until every result is in, then picks the list up again.
  task automatic test_drain_pause();
    for (int n = 0; n < 10; n++) begin
      send_cand(n == 0, pick_offset(), pick_offset(), 16'($urandom));
    end
    wait_drained();
    for (int n = 0; n < 10; n++) begin
      send_cand(1'b0, pick_offset(), pick_offset(), 16'($urandom));
    end
  endtask

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH %s: expected %0h, got %0h at %0t", name, want, got, $realtime);
      end
    end
  endtask

  // Result channel ready: a requested hold-off wins, otherwise random stalls
  // except during the calm stretch.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 8) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Every result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    near_list_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_lists.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("MISMATCH: result transaction with nothing expected at %0t", $realtime);
        end
      end else begin
        want = pending_lists.pop_front();
        flag_field("count",    32'(want.count),    32'(res_if.count));
        flag_field("taken",    32'(want.taken),    32'(res_if.taken));
        flag_field("near_id0", 32'(want.ids[0]),   32'(res_if.near_id0));
        flag_field("near_id1", 32'(want.ids[1]),   32'(res_if.near_id1));
        flag_field("near_id2", 32'(want.ids[2]),   32'(res_if.near_id2));
        flag_field("near_id3", 32'(want.ids[3]),   32'(res_if.near_id3));
        flag_field("near_d0",  want.dists[0],      res_if.near_d0);
        flag_field("near_d1",  want.dists[1],      res_if.near_d1);
        flag_field("near_d2",  want.dists[2],      res_if.near_d2);
        flag_field("near_d3",  want.dists[3],      res_if.near_d3);
      end
    end
  end

  // Watchdog: counts cycles with work outstanding and no transaction on
  // either channel.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
          (!item_if.valid && pending_lists.size() == 0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles", quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    item_if.valid      <= 1'b0;
    item_if.restart    <= 1'b0;
    item_if.dx         <= '0;
    item_if.dy         <= '0;
    item_if.cand_index <= '0;
    for (int k = 0; k < nft_pkg::KEEP; k++) begin
      list_dist[k] = '0;
      list_id[k]   = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_lists.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/nft_pkg.sv
rtl/core/nft_if.sv
rtl/core/nft_dist.sv
rtl/core/nft_list.sv
rtl/core/nearest_four_tracker_core.sv
rtl/core/nft_checker.sv
tb/sv/nearest_four_tracker_core_tb.sv
